>>> design/pwc_pkg.sv
// Shared constants, register codes and LFSR step function for the PRBS word checker.
package pwc_pkg;

    localparam int unsigned WORD_W       = 32;
    localparam int unsigned SKIP_W       = 4;
    localparam int unsigned CFG_IDX_W    = 2;
    localparam int unsigned CFG_DATA_W   = 32;

    // Counter width follows the pattern width cap of 32 bits.
    localparam int unsigned COUNTER_BITS = 32;
    localparam int unsigned CNT_W        = (COUNTER_BITS < 32) ? COUNTER_BITS : 32;
    localparam logic [WORD_W-1:0] CNT_MAX = {WORD_W{1'b1}} >> (WORD_W - CNT_W);

    localparam logic [WORD_W-1:0] SEED_RESET   = 32'h1234_5678;
    localparam logic [SKIP_W-1:0] BUDGET_RESET = 4'd4;
    localparam int unsigned       TAP_HIGH     = 31;
    localparam int unsigned       TAP_MID      = 21;

    localparam logic [CFG_IDX_W-1:0] REG_SEED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUDGET = 2'd1;

    // One Fibonacci step: shift left, feedback into bit 0.
    function automatic logic [WORD_W-1:0] lfsr_step(input logic [WORD_W-1:0] s);
        logic fb;
        fb = s[TAP_HIGH] ^ s[TAP_MID] ^ s[1] ^ s[0];
        return {s[WORD_W-2:0], fb};
    endfunction

endpackage

>>> design/pwc_if.sv
// Word channel interfaces for the PRBS word checker.
interface pwc_rx_if;
    logic                        valid;
    logic                        ready;
    logic [pwc_pkg::WORD_W-1:0]  rx_word;

    modport source (output valid, output rx_word, input ready);
    modport sink   (input valid, input rx_word, output ready);
endinterface

interface pwc_result_if;
    logic                        valid;
    logic                        ready;
    logic                        word_ok;
    logic [pwc_pkg::WORD_W-1:0]  expected_word;
    logic                        in_sync;
    logic [pwc_pkg::WORD_W-1:0]  error_total;
    logic                        first_error_seen;
    logic [pwc_pkg::WORD_W-1:0]  first_error_index;
    logic [pwc_pkg::SKIP_W-1:0]  skips_used;
    logic [pwc_pkg::WORD_W-1:0]  words_total;

    modport source (output valid, output word_ok, output expected_word, output in_sync,
                    output error_total, output first_error_seen, output first_error_index,
                    output skips_used, output words_total, input ready);
    modport sink   (input valid, input word_ok, input expected_word, input in_sync,
                    input error_total, input first_error_seen, input first_error_index,
                    input skips_used, input words_total, output ready);
endinterface

>>> design/prbs_word_checker_with_sync.sv
// PRBS word checker: one shared LFSR step unit iterated under a small sequencer.
// A taken word steps the LFSR in ST_RUN, k extra steps (0..15) only while searching;
// ST_FINISH then registers the result, holding while result_ch is stalled. A new word is
// taken only back in ST_IDLE. One shared step unit: one step plus compare per cycle.
// Reset (rst_n low, async) loads the LFSR with 0x12345678, budget 4, clears all counters.
module prbs_word_checker_with_sync
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [pwc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pwc_pkg::CFG_DATA_W-1:0]    cfg_data,
    pwc_rx_if.sink                            rx_ch,
    pwc_result_if.source                      result_ch
);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FINISH} state_t;

    state_t                          state_reg, state_next;
    logic [pwc_pkg::WORD_W-1:0]      seed_reg, seed_next;
    logic [pwc_pkg::SKIP_W-1:0]      budget_reg, budget_next;
    logic [pwc_pkg::WORD_W-1:0]      pattern_reg, pattern_next;
    logic [pwc_pkg::WORD_W-1:0]      word_reg, word_next;
    logic                            locked_reg, locked_next;
    logic [pwc_pkg::SKIP_W-1:0]      skip_reg, skip_next;
    logic [pwc_pkg::WORD_W-1:0]      err_cnt_reg, err_cnt_next;
    logic                            ferr_reg, ferr_next;
    logic [pwc_pkg::WORD_W-1:0]      ferr_pos_reg, ferr_pos_next;
    logic [pwc_pkg::WORD_W-1:0]      word_cnt_reg, word_cnt_next;
    logic                            ok_reg, ok_next;

    logic                            out_valid_reg, out_valid_next;
    logic                            out_ok_reg, out_ok_next;
    logic [pwc_pkg::WORD_W-1:0]      out_exp_reg, out_exp_next;
    logic [pwc_pkg::SKIP_W-1:0]      out_skip_reg, out_skip_next;

    logic [pwc_pkg::WORD_W-1:0]      stepped;
    logic                            hit;
    logic                            out_free;

    assign stepped  = pwc_pkg::lfsr_step(pattern_reg);
    assign hit      = (stepped == word_reg);
    assign out_free = !out_valid_reg || result_ch.ready;

    always_comb
    begin
        state_next     = state_reg;
        seed_next      = seed_reg;
        budget_next    = budget_reg;
        pattern_next   = pattern_reg;
        word_next      = word_reg;
        locked_next    = locked_reg;
        skip_next      = skip_reg;
        err_cnt_next   = err_cnt_reg;
        ferr_next      = ferr_reg;
        ferr_pos_next  = ferr_pos_reg;
        word_cnt_next  = word_cnt_reg;
        ok_next        = ok_reg;
        out_valid_next = out_valid_reg && !result_ch.ready;
        out_ok_next    = out_ok_reg;
        out_exp_next   = out_exp_reg;
        out_skip_next  = out_skip_reg;

        if (cfg_wr_en)
        begin
            case (cfg_index)
                pwc_pkg::REG_SEED:
                begin
                    seed_next    = cfg_data[pwc_pkg::WORD_W-1:0];
                    pattern_next = cfg_data[pwc_pkg::WORD_W-1:0];
                end
                pwc_pkg::REG_BUDGET:
                begin
                    budget_next = cfg_data[pwc_pkg::SKIP_W-1:0];
                end
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (rx_ch.valid)
                begin
                    word_next  = rx_ch.rx_word;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                // one LFSR step per cycle; extra steps only while searching
                pattern_next = stepped;
                if (locked_reg || hit || (skip_reg >= budget_reg))
                begin
                    ok_next    = hit;
                    state_next = ST_FINISH;
                end
                else
                begin
                    skip_next = skip_reg + 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    if (ok_reg)
                    begin
                        locked_next = 1'b1;
                    end
                    else
                    begin
                        if (!ferr_reg)
                        begin
                            ferr_next     = 1'b1;
                            ferr_pos_next = word_cnt_reg;
                        end
                        if (err_cnt_reg < pwc_pkg::CNT_MAX)
                        begin
                            err_cnt_next = err_cnt_reg + 1'b1;
                        end
                    end
                    if (word_cnt_reg < pwc_pkg::CNT_MAX)
                    begin
                        word_cnt_next = word_cnt_reg + 1'b1;
                    end
                    out_valid_next = 1'b1;
                    out_ok_next    = ok_reg;
                    out_exp_next   = pattern_reg;
                    // held here: the next word may step skip_reg while this one waits
                    out_skip_next  = skip_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seed_reg      <= pwc_pkg::SEED_RESET;
            budget_reg    <= pwc_pkg::BUDGET_RESET;
            pattern_reg   <= pwc_pkg::SEED_RESET;
            word_reg      <= '0;
            locked_reg    <= 1'b0;
            skip_reg      <= '0;
            err_cnt_reg   <= '0;
            ferr_reg      <= 1'b0;
            ferr_pos_reg  <= '0;
            word_cnt_reg  <= '0;
            ok_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            out_ok_reg    <= 1'b0;
            out_exp_reg   <= '0;
            out_skip_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            seed_reg      <= seed_next;
            budget_reg    <= budget_next;
            pattern_reg   <= pattern_next;
            word_reg      <= word_next;
            locked_reg    <= locked_next;
            skip_reg      <= skip_next;
            err_cnt_reg   <= err_cnt_next;
            ferr_reg      <= ferr_next;
            ferr_pos_reg  <= ferr_pos_next;
            word_cnt_reg  <= word_cnt_next;
            ok_reg        <= ok_next;
            out_valid_reg <= out_valid_next;
            out_ok_reg    <= out_ok_next;
            out_exp_reg   <= out_exp_next;
            out_skip_reg  <= out_skip_next;
        end
    end

    assign rx_ch.ready                  = (state_reg == ST_IDLE);
    assign result_ch.valid              = out_valid_reg;
    assign result_ch.word_ok            = out_ok_reg;
    assign result_ch.expected_word      = out_exp_reg;
    assign result_ch.in_sync            = locked_reg;
    assign result_ch.error_total        = err_cnt_reg;
    assign result_ch.first_error_seen   = ferr_reg;
    assign result_ch.first_error_index  = ferr_pos_reg;
    assign result_ch.skips_used         = out_skip_reg;
    assign result_ch.words_total        = word_cnt_reg;

    // a taken word always starts the step unit
    a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (rx_ch.valid && rx_ch.ready) |=> (state_reg == ST_RUN))
        else $error("accepted word did not start stepping");

    // skip count only grows
    a_skip_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (skip_reg >= $past(skip_reg)))
        else $error("skip count went backwards");

    // sync, once gained, is never lost
    a_lock_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        locked_reg |=> locked_reg)
        else $error("sync lost");

    a_ok_means_sync: assert property (@(posedge clk) disable iff (!rst_n)
        (result_ch.valid && result_ch.word_ok) |-> result_ch.in_sync)
        else $error("matching word shown without sync");

    a_err_le_words: assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid |-> (result_ch.error_total <= result_ch.words_total))
        else $error("more errors than words");

endmodule

>>> test/prbs_word_checker_with_sync_test.sv
// Testbench for the PRBS word checker: sync search, seed and budget settings, random traffic.
`timescale 1ns / 100ps

module prbs_word_checker_with_sync_test;

    typedef logic [pwc_pkg::WORD_W-1:0] word_t;

    // Register indexes that the block has no register behind.
    localparam logic [pwc_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [pwc_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    // Feedback taps 31, 21, 1 and 0 as one mask.
    localparam word_t FEEDBACK_MASK = 32'h8020_0003;

    localparam int WORDS_WANTED = 1450;
    localparam int CALM_TAIL    = 150;
    localparam int DRAIN_CYCLES = 20;
    localparam int STALL_LIMIT  = 1000;
    localparam int PRINT_LIMIT  = 40;

    typedef struct packed {
        logic                       word_ok;
        logic [pwc_pkg::WORD_W-1:0] expected_word;
        logic                       in_sync;
        logic [pwc_pkg::WORD_W-1:0] error_total;
        logic                       first_error_seen;
        logic [pwc_pkg::WORD_W-1:0] first_error_index;
        logic [pwc_pkg::SKIP_W-1:0] skips_used;
        logic [pwc_pkg::WORD_W-1:0] words_total;
    } verdict_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_wr_en;
    logic [pwc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [pwc_pkg::CFG_DATA_W-1:0] cfg_data;

    pwc_rx_if     rx_ch();
    pwc_result_if res_ch();

    prbs_word_checker_with_sync u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx_ch     (rx_ch),
        .result_ch (res_ch)
    );

    // Own copy of the checker state.
    logic [pwc_pkg::SKIP_W-1:0] budget_q;
    word_t                      pat_q;
    logic                       locked_q;
    logic [pwc_pkg::SKIP_W-1:0] skips_q;
    word_t                      err_cnt_q;
    logic                       err_seen_q;
    word_t                      err_pos_q;
    word_t                      word_cnt_q;

    // Transmit side pattern, used to build well-formed word streams.
    word_t tx_pat;

    verdict_t pattern_verdicts[$];

    bit idle_on;
    int words_sent;
    int fail_count;
    int stall_left;
    int quiet_cycles;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic word_t next_pattern(input word_t s);
        return {s[pwc_pkg::WORD_W-2:0], ^(s & FEEDBACK_MASK)};
    endfunction

    task automatic track_pattern(input word_t w);
        verdict_t v;
        word_t    e;
        e = next_pattern(pat_q);
        if (!locked_q)
        begin
            while (e != w && skips_q < budget_q)
            begin
                e = next_pattern(e);
                skips_q++;
            end
            if (e == w)
                locked_q = 1'b1;
        end
        pat_q = e;
        if (e != w)
        begin
            if (!err_seen_q)
            begin
                err_seen_q = 1'b1;
                err_pos_q  = word_cnt_q;
            end
            if (err_cnt_q < pwc_pkg::CNT_MAX)
                err_cnt_q++;
        end
        if (word_cnt_q < pwc_pkg::CNT_MAX)
            word_cnt_q++;
        v.word_ok           = (e == w);
        v.expected_word     = e;
        v.in_sync           = locked_q;
        v.error_total       = err_cnt_q;
        v.first_error_seen  = err_seen_q;
        v.first_error_index = err_pos_q;
        v.skips_used        = skips_q;
        v.words_total       = word_cnt_q;
        pattern_verdicts.push_back(v);
    endtask

    task automatic report_mismatch(input string what, input word_t got, input word_t want);
        if (fail_count < PRINT_LIMIT)
            $display("%0t: %s got %h want %h", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic send_word(input word_t w);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_word <= w;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        track_pattern(w);
        words_sent++;
    endtask

    // Sender holds off until every pending verdict has come back.
    task automatic settle_results();
        rx_ch.valid <= 1'b0;
        wait (pattern_verdicts.size() == 0);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [pwc_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [pwc_pkg::CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        case (idx)
            pwc_pkg::REG_SEED:
                pat_q = data;
            pwc_pkg::REG_BUDGET:
                budget_q = data[pwc_pkg::SKIP_W-1:0];
            default:
                ;
        endcase
    endtask

    task automatic send_good_words(input int n);
        repeat (n)
        begin
            tx_pat = next_pattern(tx_pat);
            send_word(tx_pat);
        end
    endtask

    // Before any match: budget used up, budget lowered below use, then a lock at the
    // far end of a full budget.
    task automatic test_sync_search();
        word_t target;
        int    reach;
        send_word($urandom);
        send_word(32'hFFFF_FFFF);
        settle_results();
        write_reg(pwc_pkg::REG_BUDGET, 32'd0);
        send_word(32'h0000_0000);
        settle_results();
        write_reg(pwc_pkg::REG_BUDGET, 32'd15);
        reach  = 15 - int'(skips_q);
        target = pat_q;
        repeat (reach + 1)
            target = next_pattern(target);
        send_word(target);
        tx_pat = pat_q;
        send_good_words(4);
        settle_results();
        write_reg(pwc_pkg::REG_BUDGET, 32'd0);
        send_good_words(2);
    endtask

    task automatic test_seed_extremes();
        settle_results();
        write_reg(pwc_pkg::REG_SEED, 32'h0000_0000);
        send_word(32'h0000_0000);
        send_word(32'h0000_0000);
        send_word(32'hFFFF_FFFF);
        send_word(32'h0000_0000);
        settle_results();
        write_reg(pwc_pkg::REG_SEED, 32'hFFFF_FFFF);
        tx_pat = pat_q;
        send_good_words(3);
        tx_pat = next_pattern(tx_pat);
        send_word(tx_pat ^ 32'h8000_0000);
        send_good_words(2);
    endtask

    task automatic test_unused_index();
        settle_results();
        write_reg(REG_SPARE_A, $urandom);
        write_reg(REG_SPARE_B, $urandom);
        tx_pat = pat_q;
        send_good_words(3);
    endtask

    task automatic test_random_traffic();
        int    len;
        int    pick;
        word_t flip;
        word_t seed;
        while (words_sent < WORDS_WANTED)
        begin
            settle_results();
            idle_on = (words_sent < WORDS_WANTED - CALM_TAIL) && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) != 0)
            begin
                pick = $urandom_range(0, 11);
                seed = (pick == 0) ? 32'h0000_0000 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
                write_reg(pwc_pkg::REG_SEED, seed);
            end
            if ($urandom_range(0, 3) == 0)
                write_reg(pwc_pkg::REG_BUDGET, $urandom_range(0, 15));
            tx_pat = pat_q;
            len = $urandom_range(20, 80);
            repeat (len)
            begin
                pick = $urandom_range(0, 99);
                tx_pat = next_pattern(tx_pat);
                if (pick < 85)
                    send_word(tx_pat);
                else if (pick < 93)
                begin
                    flip = $urandom_range(0, 1) ? (32'h1 << $urandom_range(0, 31)) : $urandom;
                    if (flip == '0)
                        flip = 32'h1;
                    send_word(tx_pat ^ flip);
                end
                else if (pick < 97)
                    send_word($urandom);
                else if (pick < 99)
                begin
                    // dropped word: the stream slips one step for the rest of the phase
                    tx_pat = next_pattern(tx_pat);
                    send_word(tx_pat);
                end
                else
                begin
                    settle_results();
                    send_word(tx_pat);
                end
                if (words_sent == WORDS_WANTED - CALM_TAIL)
                    idle_on = 1'b0;
            end
        end
    endtask

    // Result sink: ready with random stall bursts.
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1)
            res_ch.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            res_ch.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(1, 8) - 1;
            res_ch.ready <= 1'b0;
        end
        else
            res_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n === 1'b1 && res_ch.valid && res_ch.ready)
        begin
            if (pattern_verdicts.size() == 0)
                report_mismatch("unexpected result, expected_word", res_ch.expected_word, '0);
            else
            begin
                want = pattern_verdicts.pop_front();
                if (res_ch.word_ok !== want.word_ok)
                    report_mismatch("word_ok", word_t'(res_ch.word_ok),
                                    word_t'(want.word_ok));
                if (res_ch.expected_word !== want.expected_word)
                    report_mismatch("expected_word", res_ch.expected_word, want.expected_word);
                if (res_ch.in_sync !== want.in_sync)
                    report_mismatch("in_sync", word_t'(res_ch.in_sync),
                                    word_t'(want.in_sync));
                if (res_ch.error_total !== want.error_total)
                    report_mismatch("error_total", res_ch.error_total, want.error_total);
                if (res_ch.first_error_seen !== want.first_error_seen)
                    report_mismatch("first_error_seen", word_t'(res_ch.first_error_seen),
                                    word_t'(want.first_error_seen));
                if (res_ch.first_error_index !== want.first_error_index)
                    report_mismatch("first_error_index", res_ch.first_error_index,
                                    want.first_error_index);
                if (res_ch.skips_used !== want.skips_used)
                    report_mismatch("skips_used", word_t'(res_ch.skips_used),
                                    word_t'(want.skips_used));
                if (res_ch.words_total !== want.words_total)
                    report_mismatch("words_total", res_ch.words_total, want.words_total);
            end
        end
    end

    // Watchdog on cycles with no word moving on either channel.
    always @(posedge clk)
    begin
        if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_word <= '0;
        words_sent   = 0;
        idle_on      = 1'b1;
        budget_q     = pwc_pkg::BUDGET_RESET;
        pat_q        = pwc_pkg::SEED_RESET;
        locked_q     = 1'b0;
        skips_q      = '0;
        err_cnt_q    = '0;
        err_seen_q   = 1'b0;
        err_pos_q    = '0;
        word_cnt_q   = '0;
        tx_pat       = pwc_pkg::SEED_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_sync_search();
        test_seed_extremes();
        test_unused_index();
        test_random_traffic();

        idle_on = 1'b0;
        settle_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pattern_verdicts.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
